// ===== src/tpa_pkg.sv =====
package tpa_pkg;

	localparam int PERIM_W = 27;
	localparam int AREA_W  = 39;

	typedef logic [PERIM_W-1:0] perim_t;
	typedef logic [AREA_W-1:0]  area_t;

endpackage

// ===== src/tpa_if.sv =====
interface tpa_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_a_x;
	logic signed [COORD_BITS-1:0] vertex_a_y;
	logic signed [COORD_BITS-1:0] vertex_b_x;
	logic signed [COORD_BITS-1:0] vertex_b_y;
	logic signed [COORD_BITS-1:0] vertex_c_x;
	logic signed [COORD_BITS-1:0] vertex_c_y;

	modport source (
		output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
		input  ready
	);
	modport sink (
		input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
		output ready
	);
endinterface

interface tpa_out_if;
	import tpa_pkg::*;

	logic   valid;
	logic   ready;
	perim_t perimeter_q8;
	area_t  area_q8;
	logic   degenerate;

	modport source (
		output valid, perimeter_q8, area_q8, degenerate,
		input  ready
	);
	modport sink (
		input  valid, perimeter_q8, area_q8, degenerate,
		output ready
	);
endinterface

// ===== src/tpa_side_lane.sv =====
module tpa_side_lane #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [COORD_BITS-1:0]         x0,
	input  logic signed [COORD_BITS-1:0]         y0,
	input  logic signed [COORD_BITS-1:0]         x1,
	input  logic signed [COORD_BITS-1:0]         y1,
	output logic [COORD_BITS+FRAC_BITS:0]        root
);
	import tpa_pkg::*;

	localparam int DW   = COORD_BITS + 1;
	localparam int SW   = 2 * COORD_BITS + 2;
	localparam int RADW = SW + 2 * FRAC_BITS;
	localparam int RW   = RADW / 2;

	logic signed [DW-1:0] dx_c, dy_c;
	logic [DW-1:0]        dx_s1, dy_s1;
	logic [SW-1:0]        sqx_c, sqy_c;
	logic [SW-1:0]        sqx_s2, sqy_s2;
	logic [RADW-1:0]      rad_s [0:RW];
	logic [RW+1:0]        rem_s [1:RW];
	logic [RW-1:0]        root_s [1:RW];

	// signed coordinate differences; their magnitudes are taken when registered
	assign dx_c = DW'(x1) - DW'(x0);
	assign dy_c = DW'(y1) - DW'(y0);

	assign sqx_c = SW'(dx_s1) * SW'(dx_s1);
	assign sqy_c = SW'(dy_s1) * SW'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
			dy_s1    <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
			sqx_s2   <= sqx_c;
			sqy_s2   <= sqy_c;
			rad_s[0] <= RADW'(sqx_s2 + sqy_s2) << (2 * FRAC_BITS);
		end
	end

	// restoring square root, one root bit per stage
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		assign cur   = {rem_in[RW-1:0], rad_s[k][RADW-1 -: 2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_s[k] << 2;
				if (cur >= trial) begin
					rem_s[k+1]  <= cur - trial;
					root_s[k+1] <= {root_in[RW-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cur;
					root_s[k+1] <= {root_in[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RW];

endmodule

// ===== src/tpa_cross.sv =====
module tpa_cross #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	output logic [2*COORD_BITS+1:0]       cross_mag
);
	import tpa_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int XW = PW + 1;
	localparam int RW = COORD_BITS + FRAC_BITS + 1;

	logic signed [DW-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [PW-1:0] p1_s2, p2_s2;
	logic signed [XW-1:0] diff_c;
	logic [PW-1:0]        mag_s3;
	logic [PW-1:0]        mag_dly_q [RW];

	assign diff_c = XW'(p1_s2) - XW'(p2_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1 <= DW'(bx) - DW'(ax);
			e1y_s1 <= DW'(by) - DW'(ay);
			e2x_s1 <= DW'(cx) - DW'(ax);
			e2y_s1 <= DW'(cy) - DW'(ay);
			p1_s2  <= PW'(e1x_s1) * PW'(e2y_s1);
			p2_s2  <= PW'(e1y_s1) * PW'(e2x_s1);
			mag_s3 <= diff_c[XW-1] ? PW'(-diff_c) : PW'(diff_c);
			// align with the square root stages of the lanes
			mag_dly_q[0] <= mag_s3;
			for (int i = 1; i < RW; i++) begin
				mag_dly_q[i] <= mag_dly_q[i-1];
			end
		end
	end

	assign cross_mag = mag_dly_q[RW-1];

endmodule

// ===== src/tpa_merge.sv =====
module tpa_merge #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vld,
	input  logic [COORD_BITS+FRAC_BITS:0]   root_ab,
	input  logic [COORD_BITS+FRAC_BITS:0]   root_ac,
	input  logic [COORD_BITS+FRAC_BITS:0]   root_bc,
	input  logic [2*COORD_BITS+1:0]         cross_mag,
	output logic                            adv,
	tpa_out_if.source                       results
);
	import tpa_pkg::*;

	localparam int RW  = COORD_BITS + FRAC_BITS + 1;
	localparam int SUW = RW + 2;
	localparam int MW  = 2 * COORD_BITS + 2;
	localparam int AWI = MW + FRAC_BITS;

	logic [SUW-1:0] perim_c;
	logic [AWI-1:0] area_c;
	logic           out_vld_q;
	perim_t         perim_q;
	area_t          area_q;
	logic           degen_q;

	assign perim_c = SUW'(root_ab) + SUW'(root_ac) + SUW'(root_bc);

	if (FRAC_BITS >= 1) begin : g_frac
		assign area_c = AWI'(cross_mag) << (FRAC_BITS - 1);
	end else begin : g_nofrac
		assign area_c = AWI'(cross_mag >> 1);
	end

	assign adv = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld) begin
			perim_q <= PERIM_W'(perim_c);
			area_q  <= AREA_W'(area_c);
			degen_q <= (cross_mag == '0);
		end
	end

	assign results.valid        = out_vld_q;
	assign results.perimeter_q8 = perim_q;
	assign results.area_q8      = area_q;
	assign results.degenerate   = degen_q;

endmodule

// ===== src/triangle_perimeter_area.sv =====
// triangle perimeter and area, fully pipelined
// its depth is set by the square root pipeline of one stage per root bit in
// each of the three side lanes
// throughput: one item per cycle; a stalled output holds the whole pipeline
// reset: arst_n clears all valid flags, payload registers are not reset
module triangle_perimeter_area #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	tpa_in_if.sink     vertices,
	tpa_out_if.source  results
);
	import tpa_pkg::*;

	localparam int RW  = COORD_BITS + FRAC_BITS + 1;
	localparam int LAT = RW + 3;
	localparam int MW  = 2 * COORD_BITS + 2;

	logic          adv;
	logic [LAT-1:0] vld_q;
	logic [RW-1:0] root_ab, root_ac, root_bc;
	logic [MW-1:0] cross_mag;

	assign vertices.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], vertices.valid};
		end
	end

	tpa_side_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_ab (
		.clk  (clk),
		.en   (adv),
		.x0   (vertices.vertex_a_x),
		.y0   (vertices.vertex_a_y),
		.x1   (vertices.vertex_b_x),
		.y1   (vertices.vertex_b_y),
		.root (root_ab)
	);

	tpa_side_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_ac (
		.clk  (clk),
		.en   (adv),
		.x0   (vertices.vertex_a_x),
		.y0   (vertices.vertex_a_y),
		.x1   (vertices.vertex_c_x),
		.y1   (vertices.vertex_c_y),
		.root (root_ac)
	);

	tpa_side_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_bc (
		.clk  (clk),
		.en   (adv),
		.x0   (vertices.vertex_b_x),
		.y0   (vertices.vertex_b_y),
		.x1   (vertices.vertex_c_x),
		.y1   (vertices.vertex_c_y),
		.root (root_bc)
	);

	tpa_cross #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cross (
		.clk       (clk),
		.en        (adv),
		.ax        (vertices.vertex_a_x),
		.ay        (vertices.vertex_a_y),
		.bx        (vertices.vertex_b_x),
		.by        (vertices.vertex_b_y),
		.cx        (vertices.vertex_c_x),
		.cy        (vertices.vertex_c_y),
		.cross_mag (cross_mag)
	);

	tpa_merge #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_q[LAT-1]),
		.root_ab   (root_ab),
		.root_ac   (root_ac),
		.root_bc   (root_bc),
		.cross_mag (cross_mag),
		.adv       (adv),
		.results   (results)
	);

endmodule

// ===== dv/triangle_perimeter_area_tb.sv =====
`timescale 1ns / 1ps

module triangle_perimeter_area_tb;
	import tpa_pkg::*;

	localparam int COORD_W      = 16;
	localparam int FRAC_W       = 8;
	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_MAX   = 10;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		coord_t cx;
		coord_t cy;
	} triangle_t;

	typedef struct packed {
		perim_t perim;
		area_t  area;
		logic   degen;
	} measure_t;

	typedef struct {
		triangle_t vtx;
		bit        typed;
		measure_t  known;
	} directed_row_t;

	logic clk;
	logic arst_n;

	tpa_in_if #(.COORD_BITS(COORD_W)) vert_ch ();
	tpa_out_if res_ch ();

	triangle_perimeter_area #(
		.COORD_BITS(COORD_W),
		.FRAC_BITS (FRAC_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vertices(vert_ch.sink),
		.results (res_ch.source)
	);

	measure_t      pending_meas[$];
	directed_row_t directed_rows[$];
	measure_t      head_meas;

	int fault_count    = 0;
	int result_count   = 0;
	int degen_count    = 0;
	int directed_count = 0;
	int random_count   = 0;
	bit hold_request   = 0;
	bit hold_done      = 0;

	function automatic logic [31:0] root_floor(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] trial;
		int i;
		root = '0;
		rem  = '0;
		for (i = 31; i >= 0; i--) begin
			rem   = {rem[61:0], n[2*i +: 2]};
			trial = {root[61:0], 2'b01};
			if (rem >= trial) begin
				rem  = rem - trial;
				root = {root[62:0], 1'b1};
			end else begin
				root = {root[62:0], 1'b0};
			end
		end
		return root[31:0];
	endfunction

	function automatic logic [63:0] side_q8(longint dx, longint dy);
		logic [63:0] sq;
		sq = 64'(dx * dx + dy * dy);
		return 64'(root_floor(sq << (2 * FRAC_W)));
	endfunction

	function automatic measure_t measure_triangle(triangle_t t);
		longint ax, ay, bx, by, cx, cy, xprod;
		logic [63:0] perim_sum;
		logic [63:0] area_full;
		measure_t m;
		ax = $signed(t.ax);
		ay = $signed(t.ay);
		bx = $signed(t.bx);
		by = $signed(t.by);
		cx = $signed(t.cx);
		cy = $signed(t.cy);
		perim_sum = side_q8(bx - ax, by - ay) + side_q8(cx - ax, cy - ay)
			+ side_q8(cx - bx, cy - by);
		xprod = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		if (xprod < 0) begin
			xprod = -xprod;
		end
		area_full = 64'(xprod) << (FRAC_W - 1);
		m.perim = perim_sum[PERIM_W-1:0];
		m.area  = area_full[AREA_W-1:0];
		m.degen = (xprod == 0);
		return m;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 4))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(0);
			3: return coord_t'(-1);
			default: return coord_t'(1);
		endcase
	endfunction

	task automatic add_row(int ax, int ay, int bx, int by, int cx, int cy,
		bit typed, longint perim, longint area, bit degen);
		directed_row_t row;
		row.vtx.ax      = coord_t'(ax);
		row.vtx.ay      = coord_t'(ay);
		row.vtx.bx      = coord_t'(bx);
		row.vtx.by      = coord_t'(by);
		row.vtx.cx      = coord_t'(cx);
		row.vtx.cy      = coord_t'(cy);
		row.typed       = typed;
		row.known.perim = perim_t'(perim);
		row.known.area  = area_t'(area);
		row.known.degen = degen;
		directed_rows.push_back(row);
	endtask

	task automatic send_triangle(triangle_t t, bit typed, measure_t known, int gap);
		vert_ch.valid      <= 1'b1;
		vert_ch.vertex_a_x <= t.ax;
		vert_ch.vertex_a_y <= t.ay;
		vert_ch.vertex_b_x <= t.bx;
		vert_ch.vertex_b_y <= t.by;
		vert_ch.vertex_c_x <= t.cx;
		vert_ch.vertex_c_y <= t.cy;
		do @(posedge clk); while (vert_ch.ready !== 1'b1);
		pending_meas.push_back(typed ? known : measure_triangle(t));
		if (gap > 0) begin
			vert_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// output side back-pressure, with one long hold-off once the sender is streaming
	initial begin : ready_gen
		int on_len;
		int gap;
		res_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end
			on_len = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			res_ch.ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			result_count++;
			if (res_ch.degenerate === 1'b1) begin
				degen_count++;
			end
			if (pending_meas.size() == 0) begin
				if (fault_count < REPORT_MAX) begin
					$display("unexpected result: perimeter %0d area %0d degenerate %0b",
						res_ch.perimeter_q8, res_ch.area_q8, res_ch.degenerate);
				end
				fault_count++;
			end else begin
				head_meas = pending_meas.pop_front();
				if (res_ch.perimeter_q8 !== head_meas.perim || res_ch.area_q8 !== head_meas.area
					|| res_ch.degenerate !== head_meas.degen) begin
					if (fault_count < REPORT_MAX) begin
						$display("result %0d mismatch: expected perimeter %0d area %0d degenerate %0b",
							result_count, head_meas.perim, head_meas.area, head_meas.degen);
						$display("result %0d mismatch:      got perimeter %0d area %0d degenerate %0b",
							result_count, res_ch.perimeter_q8, res_ch.area_q8, res_ch.degenerate);
					end
					fault_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (arst_n !== 1'b1) @(posedge clk);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((vert_ch.valid === 1'b1 && vert_ch.ready === 1'b1)
				|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("watchdog: no item accepted for %0d cycles, %0d results outstanding",
			IDLE_LIMIT, pending_meas.size());
		$display("triangle_perimeter_area verification failed");
		$finish;
	end

	initial begin : stimulus
		triangle_t t;
		measure_t  none;
		int i;
		int kind;
		int sh;
		int ax, ay, dx, dy, k1, k2;
		none = '0;
		arst_n             <= 1'b0;
		vert_ch.valid      <= 1'b0;
		vert_ch.vertex_a_x <= '0;
		vert_ch.vertex_a_y <= '0;
		vert_ch.vertex_b_x <= '0;
		vert_ch.vertex_b_y <= '0;
		vert_ch.vertex_c_x <= '0;
		vert_ch.vertex_c_y <= '0;

		// coincident, collinear and exact cases typed in, the rest predicted
		add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
		add_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0, 1);
		add_row(32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 1);
		add_row(0, 0, 1, 0, 2, 0, 1, 1024, 0, 1);
		add_row(5, 5, 5, 5, 5, 9, 1, 2048, 0, 1);
		add_row(0, 0, 3, 0, 0, 4, 1, 3072, 1536, 0);
		add_row(0, 0, 0, 4, 3, 0, 1, 3072, 1536, 0);
		add_row(-1, -1, -4, -1, -1, -5, 1, 3072, 1536, 0);
		add_row(0, 0, 1, 0, 0, 1, 1, 874, 128, 0);
		add_row(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, 0, 0);
		add_row(32767, 32767, -32768, 32767, 32767, -32768, 0, 0, 0, 0);
		add_row(-32768, -32768, 0, 0, 32767, 32767, 0, 0, 0, 0);
		add_row(21845, -21846, -21846, 21845, 21845, 21845, 0, 0, 0, 0);
		add_row(-32768, 32767, 32767, -32768, 0, 0, 0, 0, 0, 0);
		add_row(1, -1, -1, 1, -1, -1, 0, 0, 0, 0);
		add_row(32767, 0, -32768, 0, 0, 32767, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_triangle(directed_rows[r].vtx, directed_rows[r].typed, directed_rows[r].known,
				pick_gap());
			directed_count++;
		end

		hold_request = 1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			t    = triangle_t'({$urandom(), $urandom(), $urandom()});
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
				end
				4, 5: begin
					sh   = $urandom_range(6, 13);
					t.ax = $signed(t.ax) >>> sh;
					t.ay = $signed(t.ay) >>> sh;
					t.bx = $signed(t.bx) >>> sh;
					t.by = $signed(t.by) >>> sh;
					t.cx = $signed(t.cx) >>> sh;
					t.cy = $signed(t.cy) >>> sh;
				end
				6: begin
					ax   = int'($urandom_range(0, 16000)) - 8000;
					ay   = int'($urandom_range(0, 16000)) - 8000;
					dx   = int'($urandom_range(0, 1000)) - 500;
					dy   = int'($urandom_range(0, 1000)) - 500;
					k1   = int'($urandom_range(0, 8)) - 4;
					k2   = int'($urandom_range(0, 8)) - 4;
					t.ax = coord_t'(ax);
					t.ay = coord_t'(ay);
					t.bx = coord_t'(ax + k1 * dx);
					t.by = coord_t'(ay + k1 * dy);
					t.cx = coord_t'(ax + k2 * dx);
					t.cy = coord_t'(ay + k2 * dy);
				end
				7: begin
					t.bx = t.ax;
					t.by = t.ay;
				end
				8: begin
					t.ax = pick_extreme();
					t.ay = pick_extreme();
					t.bx = pick_extreme();
					t.by = pick_extreme();
					t.cx = pick_extreme();
					t.cy = pick_extreme();
				end
				default: begin
					t.bx = t.ax;
					t.cy = t.ay;
				end
			endcase
			// no sender gaps until the long output hold-off has played out
			send_triangle(t, 0, none, hold_done ? pick_gap() : 0);
			random_count++;
		end
		vert_ch.valid <= 1'b0;

		while (pending_meas.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d directed and %0d random triangles, %0d results, %0d degenerate",
			directed_count, random_count, result_count, degen_count);
		$display("output held off %0d cycles once while the input kept streaming; %0d faults",
			HOLD_CYCLES, fault_count);
		if (fault_count == 0) begin
			$display("triangle_perimeter_area verification clean");
		end else begin
			$display("triangle_perimeter_area verification failed");
		end
		$finish;
	end

endmodule
